// ----- hdl/assert_macros.svh -----
// assertion macros used by the sdc top-level rtl file
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SDC_ASSERT(lbl, prop, msg)
`define SDC_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hdl/sdc_pkg.sv -----
// shared types and codes for the deferred correction block
// no dependencies
package sdc_pkg;

  // request kinds
  localparam logic [1:0] KIND_WR_U   = 2'd0;
  localparam logic [1:0] KIND_WR_V   = 2'd1;
  localparam logic [1:0] KIND_CORR_U = 2'd2;
  localparam logic [1:0] KIND_CORR_V = 2'd3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_SECOND_ORDER = 2'd0;
  localparam logic [1:0] REG_ROW_LIMIT    = 2'd1;
  localparam logic [1:0] REG_COL_LIMIT    = 2'd2;

  // face lanes
  localparam int NUM_FACES  = 4;
  localparam int FACE_EAST  = 0;
  localparam int FACE_WEST  = 1;
  localparam int FACE_NORTH = 2;
  localparam int FACE_SOUTH = 3;

  localparam int FLUX_W = 32;
  localparam int OUT_W  = 32;

  typedef struct packed {
    logic start;  // capture the face flux
    logic load;   // capture the stencil pair
    logic ok;     // stencil passes bound and grid tests
  } lane_ctl_t;

  typedef struct packed {
    logic emit;
    logic second_order;
  } merge_ctl_t;

endpackage

// ----- hdl/sdc_ram.sv -----
// generic ram: one write port, two registered read ports
// no dependencies
module sdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hdl/sdc_lane.sv -----
// one face lane: stencil difference, flux product, rounded half scaling
// depends on sdc_pkg
module sdc_lane #(
  parameter int SB = 32
) (
  input  logic                            clk,
  input  sdc_pkg::lane_ctl_t              ctl,
  input  logic signed [sdc_pkg::FLUX_W-1:0] flux,
  input  logic [SB-1:0]                   rd_a,
  input  logic [SB-1:0]                   rd_b,
  output logic signed [SB+15:0]           term
);

  localparam int PW = SB + sdc_pkg::FLUX_W + 1;
  localparam logic signed [PW-1:0] HALF = PW'(65536);

  logic signed [sdc_pkg::FLUX_W-1:0] flux_r;
  logic signed [SB:0]                diff_r, diff_nxt;
  logic signed [PW-1:0]              prod_r, prod_nxt;
  logic signed [PW-1:0]              rnd;
  logic signed [SB+15:0]             term_r;

  always_comb begin
    diff_nxt = ctl.ok ? ($signed({rd_a[SB-1], rd_a}) - $signed({rd_b[SB-1], rd_b})) : '0;
    prod_nxt = flux_r * diff_r;
    // floor((p + 2^16) / 2^17)
    rnd      = prod_r + HALF;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      flux_r <= flux;
    end
    if (ctl.load) begin
      diff_r <= diff_nxt;
    end
    prod_r <= prod_nxt;
    term_r <= rnd[PW-1:17];
  end

  assign term = term_r;

endmodule

// ----- hdl/sdc_merge.sv -----
// merge stage: signed sum of the four face terms, saturation, result register
// depends on sdc_pkg
module sdc_merge #(
  parameter int SB = 32
) (
  input  logic                              clk,
  input  sdc_pkg::merge_ctl_t               ctl,
  input  logic signed [SB+15:0]             term [sdc_pkg::NUM_FACES],
  output logic signed [sdc_pkg::OUT_W-1:0]  correction,
  output logic                              saturated
);

  localparam int TW = SB + 16;
  localparam int SW = TW + 2;
  localparam logic signed [SW-1:0] MAXV = $signed({{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}});
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  logic signed [SW-1:0]              sum_r, sum_nxt;
  logic signed [SW-1:0]              clip;
  logic                              clip_hit;
  logic signed [sdc_pkg::OUT_W-1:0]  corr_r, corr_nxt;
  logic                              sat_r, sat_nxt;

  always_comb begin
    // west and south add, east and north subtract
    sum_nxt = SW'(term[sdc_pkg::FACE_WEST]) + SW'(term[sdc_pkg::FACE_SOUTH])
            - SW'(term[sdc_pkg::FACE_EAST]) - SW'(term[sdc_pkg::FACE_NORTH]);
  end

  always_comb begin
    clip     = sum_r;
    clip_hit = 1'b0;
    if (sum_r > MAXV) begin
      clip     = MAXV;
      clip_hit = 1'b1;
    end else if (sum_r < MINV) begin
      clip     = MINV;
      clip_hit = 1'b1;
    end
    corr_nxt = ctl.second_order ? sdc_pkg::OUT_W'($signed(clip[SB-1:0])) : '0;
    sat_nxt  = ctl.second_order & clip_hit;
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (ctl.emit) begin
      corr_r <= corr_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign correction = corr_r;
  assign saturated  = sat_r;

endmodule

// ----- hdl/sou_deferred_correction.sv -----
// top level: config registers, u/v field rams, read sequencer, four face lanes, merge
// depends on sdc_pkg, sdc_ram, sdc_lane, sdc_merge and assert_macros.svh
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   in       | in_valid / in_stall   | kind, row, col, cell_value, four fluxes
//   out      | out_valid / out_stall | correction, saturated
//   cfg      | psel/penable/pwrite   | paddr, pwdata, prdata, pready (always 1)
//
// a write request is taken while idle; the next request can follow at once
// a correction request runs through ram reads (one face per cycle on the two read
// ports), the lane difference, multiply and rounding registers, a sum and an emit
// in_stall is high while a correction is in flight; emit waits while out_stall
// holds an earlier result. reset sets control and config defaults, not the fields
`include "assert_macros.svh"
module sou_deferred_correction #(
  parameter int unsigned GRID_ROWS  = 64,
  parameter int unsigned GRID_COLS  = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_kind,
  input  logic [5:0]                         in_row,
  input  logic [5:0]                         in_col,
  input  logic signed [31:0]                 in_cell_value,
  input  logic signed [sdc_pkg::FLUX_W-1:0]  in_flux_east,
  input  logic signed [sdc_pkg::FLUX_W-1:0]  in_flux_west,
  input  logic signed [sdc_pkg::FLUX_W-1:0]  in_flux_north,
  input  logic signed [sdc_pkg::FLUX_W-1:0]  in_flux_south,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sdc_pkg::OUT_W-1:0]   out_correction,
  output logic                               out_saturated,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int SB        = (VALUE_BITS < 32) ? int'(VALUE_BITS) : 32;
  localparam int ROWS_USED = (GRID_ROWS < 64) ? int'(GRID_ROWS) : 64;
  localparam int COLS_USED = (GRID_COLS < 64) ? int'(GRID_COLS) : 64;
  localparam int RB        = $clog2(ROWS_USED);
  localparam int CB        = $clog2(COLS_USED);
  localparam int AW        = RB + CB;
  localparam int DEPTH     = 1 << AW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [2:0] LAST_STEP = 3'd7;

  // config registers
  logic       so_cfg_r, so_cfg_nxt;
  logic [5:0] row_lim_r, row_lim_nxt;
  logic [5:0] col_lim_r, col_lim_nxt;
  logic       cfg_wr;

  // sequencer
  logic [1:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] kind_r;
  logic [5:0] row_r, col_r;
  logic [3:0] fneg_r;
  logic       so_r;
  logic       accept, is_write, emit;

  // stencil
  logic [6:0] r0, rp1, rp2, rm1, rm2;
  logic [6:0] c0, cp1, cp2, cm1, cm2;
  logic [6:0] rl7, cl7;
  logic       is_v;
  logic [6:0] fa_r [sdc_pkg::NUM_FACES];
  logic [6:0] fa_c [sdc_pkg::NUM_FACES];
  logic [6:0] fb_r [sdc_pkg::NUM_FACES];
  logic [6:0] fb_c [sdc_pkg::NUM_FACES];
  logic [sdc_pkg::NUM_FACES-1:0] face_bnd, face_ok;
  logic [1:0] face_sel;

  // ram ports
  logic          we_u, we_v, wr_in_grid;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [SB-1:0] u_rd_a, u_rd_b, v_rd_a, v_rd_b, rd_a, rd_b;

  logic signed [sdc_pkg::FLUX_W-1:0] flux_in [sdc_pkg::NUM_FACES];
  logic signed [SB+15:0]             term [sdc_pkg::NUM_FACES];
  sdc_pkg::merge_ctl_t               mctl;

  function automatic logic in_grid(input logic [6:0] r, input logic [6:0] c);
    in_grid = ({25'd0, r} < GRID_ROWS) && ({25'd0, c} < GRID_COLS);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] r, input logic [6:0] c);
    cell_addr = {r[RB-1:0], c[CB-1:0]};
  endfunction

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    so_cfg_nxt  = so_cfg_r;
    row_lim_nxt = row_lim_r;
    col_lim_nxt = col_lim_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        sdc_pkg::REG_SECOND_ORDER: so_cfg_nxt  = pwdata[0];
        sdc_pkg::REG_ROW_LIMIT:    row_lim_nxt = pwdata[5:0];
        sdc_pkg::REG_COL_LIMIT:    col_lim_nxt = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sdc_pkg::REG_SECOND_ORDER: prdata = {31'd0, so_cfg_r};
      sdc_pkg::REG_ROW_LIMIT:    prdata = {26'd0, row_lim_r};
      sdc_pkg::REG_COL_LIMIT:    prdata = {26'd0, col_lim_r};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- request intake and sequencer ----------------
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign is_write = (in_kind == sdc_pkg::KIND_WR_U) || (in_kind == sdc_pkg::KIND_WR_V);
  assign emit     = (state_r == ST_EMIT) & (~out_valid_r | ~out_stall);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_write) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      so_cfg_r    <= 1'b1;
      row_lim_r   <= 6'd63;
      col_lim_r   <= 6'd63;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      so_cfg_r    <= so_cfg_nxt;
      row_lim_r   <= row_lim_nxt;
      col_lim_r   <= col_lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      row_r  <= in_row;
      col_r  <= in_col;
      fneg_r <= {in_flux_south[31], in_flux_north[31], in_flux_west[31], in_flux_east[31]};
      so_r   <= so_cfg_r;
    end
  end

  // ---------------- field writes ----------------
  assign wr_in_grid = in_grid({1'b0, in_row}, {1'b0, in_col});
  assign we_u  = accept && (in_kind == sdc_pkg::KIND_WR_U) && wr_in_grid;
  assign we_v  = accept && (in_kind == sdc_pkg::KIND_WR_V) && wr_in_grid;
  assign waddr = cell_addr({1'b0, in_row}, {1'b0, in_col});

  // ---------------- stencil addresses ----------------
  always_comb begin
    r0  = {1'b0, row_r};
    c0  = {1'b0, col_r};
    rp1 = r0 + 7'd1;
    rp2 = r0 + 7'd2;
    rm1 = r0 - 7'd1;
    rm2 = r0 - 7'd2;
    cp1 = c0 + 7'd1;
    cp2 = c0 + 7'd2;
    cm1 = c0 - 7'd1;
    cm2 = c0 - 7'd2;
    rl7 = {1'b0, row_lim_r};
    cl7 = {1'b0, col_lim_r};
    is_v = (kind_r == sdc_pkg::KIND_CORR_V);

    // u grid: column tests strict, row tests inclusive; v grid the reverse
    if (!fneg_r[sdc_pkg::FACE_EAST]) begin
      face_bnd[sdc_pkg::FACE_EAST] = (c0 >= 7'd2);
      fa_r[sdc_pkg::FACE_EAST] = r0;  fa_c[sdc_pkg::FACE_EAST] = c0;
      fb_r[sdc_pkg::FACE_EAST] = r0;  fb_c[sdc_pkg::FACE_EAST] = cm1;
    end else begin
      face_bnd[sdc_pkg::FACE_EAST] = is_v ? (cp2 <= cl7) : (cp2 < cl7);
      fa_r[sdc_pkg::FACE_EAST] = r0;  fa_c[sdc_pkg::FACE_EAST] = cp1;
      fb_r[sdc_pkg::FACE_EAST] = r0;  fb_c[sdc_pkg::FACE_EAST] = cp2;
    end

    if (!fneg_r[sdc_pkg::FACE_WEST]) begin
      face_bnd[sdc_pkg::FACE_WEST] = (c0 >= 7'd2);
      fa_r[sdc_pkg::FACE_WEST] = r0;  fa_c[sdc_pkg::FACE_WEST] = cm1;
      fb_r[sdc_pkg::FACE_WEST] = r0;  fb_c[sdc_pkg::FACE_WEST] = cm2;
    end else begin
      face_bnd[sdc_pkg::FACE_WEST] = is_v ? (cp1 <= cl7) : (cp1 < cl7);
      fa_r[sdc_pkg::FACE_WEST] = r0;  fa_c[sdc_pkg::FACE_WEST] = c0;
      fb_r[sdc_pkg::FACE_WEST] = r0;  fb_c[sdc_pkg::FACE_WEST] = cp1;
    end

    if (!fneg_r[sdc_pkg::FACE_NORTH]) begin
      face_bnd[sdc_pkg::FACE_NORTH] = (r0 >= 7'd1);
      fa_r[sdc_pkg::FACE_NORTH] = r0;   fa_c[sdc_pkg::FACE_NORTH] = c0;
      fb_r[sdc_pkg::FACE_NORTH] = rm1;  fb_c[sdc_pkg::FACE_NORTH] = c0;
    end else begin
      face_bnd[sdc_pkg::FACE_NORTH] = is_v ? (rp2 < rl7) : (rp2 <= rl7);
      fa_r[sdc_pkg::FACE_NORTH] = rp1;  fa_c[sdc_pkg::FACE_NORTH] = c0;
      fb_r[sdc_pkg::FACE_NORTH] = rp2;  fb_c[sdc_pkg::FACE_NORTH] = c0;
    end

    if (!fneg_r[sdc_pkg::FACE_SOUTH]) begin
      face_bnd[sdc_pkg::FACE_SOUTH] = (r0 >= 7'd2);
      fa_r[sdc_pkg::FACE_SOUTH] = rm1;  fa_c[sdc_pkg::FACE_SOUTH] = c0;
      fb_r[sdc_pkg::FACE_SOUTH] = rm2;  fb_c[sdc_pkg::FACE_SOUTH] = c0;
    end else begin
      face_bnd[sdc_pkg::FACE_SOUTH] = is_v ? (rp1 < rl7) : (rp1 <= rl7);
      fa_r[sdc_pkg::FACE_SOUTH] = r0;   fa_c[sdc_pkg::FACE_SOUTH] = c0;
      fb_r[sdc_pkg::FACE_SOUTH] = rp1;  fb_c[sdc_pkg::FACE_SOUTH] = c0;
    end

    for (int k = 0; k < sdc_pkg::NUM_FACES; k++) begin
      face_ok[k] = face_bnd[k] && in_grid(fa_r[k], fa_c[k]) && in_grid(fb_r[k], fb_c[k]);
    end
  end

  // one face per read cycle
  assign face_sel = step_r[1:0];
  assign raddr_a  = cell_addr(fa_r[face_sel], fa_c[face_sel]);
  assign raddr_b  = cell_addr(fb_r[face_sel], fb_c[face_sel]);

  sdc_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_field_ram (
    .clk     (clk),
    .we      (we_u),
    .waddr   (waddr),
    .wdata   (in_cell_value[SB-1:0]),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (u_rd_a),
    .rdata_b (u_rd_b)
  );

  sdc_ram #(.WIDTH(SB), .DEPTH(DEPTH)) v_field_ram (
    .clk     (clk),
    .we      (we_v),
    .waddr   (waddr),
    .wdata   (in_cell_value[SB-1:0]),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (v_rd_a),
    .rdata_b (v_rd_b)
  );

  assign rd_a = is_v ? v_rd_a : u_rd_a;
  assign rd_b = is_v ? v_rd_b : u_rd_b;

  // ---------------- face lanes ----------------
  assign flux_in[sdc_pkg::FACE_EAST]  = in_flux_east;
  assign flux_in[sdc_pkg::FACE_WEST]  = in_flux_west;
  assign flux_in[sdc_pkg::FACE_NORTH] = in_flux_north;
  assign flux_in[sdc_pkg::FACE_SOUTH] = in_flux_south;

  for (genvar k = 0; k < sdc_pkg::NUM_FACES; k++) begin : g_lane
    sdc_pkg::lane_ctl_t lctl;

    // ram data for face k is back in the cycle after its read step
    assign lctl.start = accept;
    assign lctl.load  = (state_r == ST_RUN) && (step_r == 3'(k + 1));
    assign lctl.ok    = face_ok[k];

    sdc_lane #(.SB(SB)) u_lane (
      .clk  (clk),
      .ctl  (lctl),
      .flux (flux_in[k]),
      .rd_a (rd_a),
      .rd_b (rd_b),
      .term (term[k])
    );
  end

  // ---------------- merge ----------------
  assign mctl.emit         = emit;
  assign mctl.second_order = so_r;

  sdc_merge #(.SB(SB)) u_merge (
    .clk        (clk),
    .ctl        (mctl),
    .term       (term),
    .correction (out_correction),
    .saturated  (out_saturated)
  );

  assign out_valid = out_valid_r;

  // ---------------- checks ----------------
  `SDC_ASSERT_NEVER(a_no_write_busy, (we_u || we_v) && (state_r != ST_IDLE), "field write while busy")
  `SDC_ASSERT(a_result_from_emit, $rose(out_valid_r) |-> $past(state_r == ST_EMIT), "result without emit")
  `SDC_ASSERT(a_run_to_emit, (state_r == ST_RUN && step_r == LAST_STEP) |=> (state_r == ST_EMIT), "sequencer skipped emit")
  `SDC_ASSERT(a_emit_done, emit |=> (state_r == ST_IDLE && out_valid_r), "emit did not present result")
  `SDC_ASSERT(a_first_order_zero, (emit && !so_r) |=> (out_correction == '0 && !out_saturated), "first-order result not zero")

endmodule
